// ----- rtl/bfiq_pkg.sv -----
// Package for the Bloom filter insert/query block: sizes, types, helpers.
// No dependencies; imported by bfiq_probe, bfiq_rmw and the top level (not by bfiq_ram).
`timescale 1ns / 1ps

package bfiq_pkg;

    // sizing of the bit store
    localparam int MAX_BITS     = 65536;
    localparam int WORD_BITS    = 64;
    localparam int MAX_PROBES   = 100;
    localparam int FILTER_DEPTH = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W       = $clog2(FILTER_DEPTH);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int POS_W        = $clog2(MAX_BITS);

    // field and register widths
    localparam int HASH_W       = 64;
    localparam int HALF_W       = HASH_W / 2;
    localparam int NUM_BITS_W   = 17;
    localparam int NUM_PROBES_W = 7;
    localparam int CNT_W        = $clog2(MAX_PROBES + 1);
    localparam int CFG_DATA_W   = NUM_BITS_W;
    localparam int CFG_IDX_W    = 2;
    localparam int PROD_W       = HALF_W + NUM_BITS_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PROBES = CFG_IDX_W'(1);

    // reset values
    localparam logic [NUM_BITS_W-1:0]   RST_NUM_BITS   = NUM_BITS_W'(65536);
    localparam logic [NUM_PROBES_W-1:0] RST_NUM_PROBES = NUM_PROBES_W'(7);

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN
    } t_state;

    // one probe position headed for the bit store
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } t_probe;

    // status of the read-modify-write path
    typedef struct packed {
        logic clearing;
        logic inflight;
        logic all_set;
    } t_rmw_stat;

    // zero acts as one, above MAX_BITS saturates
    function automatic logic [NUM_BITS_W-1:0] eff_bits(input logic [NUM_BITS_W-1:0] v);
        logic [NUM_BITS_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = NUM_BITS_W'(1);
        end else if (v > NUM_BITS_W'(MAX_BITS)) begin
            r = NUM_BITS_W'(MAX_BITS);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] eff_probes(input logic [NUM_PROBES_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (32'(v) > MAX_PROBES) begin
            r = CNT_W'(MAX_PROBES);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/bfiq_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old word. No dependencies.
`timescale 1ns / 1ps

module bfiq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bfiq_probe.sv -----
// Probe generator: steps x = h1 + i*h2 and range-reduces it to a bit position.
// Depends on bfiq_pkg.
`timescale 1ns / 1ps

module bfiq_probe (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [bfiq_pkg::HASH_W-1:0]      i_key_hash,
    input  logic [bfiq_pkg::CNT_W-1:0]       i_probes,
    input  logic [bfiq_pkg::NUM_BITS_W-1:0]  i_bits,
    output bfiq_pkg::t_probe                 o_probe,
    output logic                             o_pending
);
    import bfiq_pkg::*;

    logic [HALF_W-1:0] r_x;
    logic [HALF_W-1:0] r_h2;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_valid;
    logic [POS_W-1:0]  r_pos;
    logic [PROD_W-1:0] prod;

    // multiply-high range reduction; result is below i_bits
    assign prod = PROD_W'(r_x) * PROD_W'(i_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_cnt   <= i_probes;
            r_valid <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt   <= r_cnt - CNT_W'(1);
            r_valid <= 1'b1;
        end else begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x  <= i_key_hash[HALF_W-1:0];
            r_h2 <= i_key_hash[HASH_W-1:HALF_W];
        end else if (r_cnt != '0) begin
            r_x   <= r_x + r_h2;
            r_pos <= prod[HALF_W +: POS_W];
        end
    end

    assign o_probe.valid = r_valid;
    assign o_probe.pos   = r_pos;
    assign o_pending     = (r_cnt != '0);

endmodule

// ----- rtl/bfiq_rmw.sv -----
// Read-modify-write path on the filter store, plus the clearing sweep after reset.
// Depends on bfiq_pkg and bfiq_ram.
`timescale 1ns / 1ps

module bfiq_rmw (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_func,
    input  bfiq_pkg::t_probe    i_probe,
    output bfiq_pkg::t_rmw_stat o_stat
);
    import bfiq_pkg::*;

    logic                 r_clearing;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic                 r_c_valid;
    logic [ADDR_W-1:0]    r_c_addr;
    logic [BIT_W-1:0]     r_c_bit;
    logic                 r_fwd_valid;
    logic [ADDR_W-1:0]    r_fwd_addr;
    logic [WORD_BITS-1:0] r_fwd_data;
    logic                 r_all;
    logic                 n_all;

    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] word;

    assign raddr = i_probe.pos[POS_W-1:BIT_W];

    bfiq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (FILTER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // the write issued in the read cycle is not yet in rdata
    assign word = (r_fwd_valid && (r_fwd_addr == r_c_addr)) ? r_fwd_data : rdata;

    always_comb begin
        we    = 1'b0;
        waddr = r_c_addr;
        wdata = word | (WORD_BITS'(1) << r_c_bit);
        n_all = r_all;
        if (r_clearing) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else if (r_c_valid) begin
            if (i_func == FUNC_INSERT) begin
                we = 1'b1;
            end else if (!word[r_c_bit]) begin
                n_all = 1'b0;
            end
        end
        if (i_load) begin
            n_all = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_c_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_all       <= 1'b1;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(FILTER_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_c_valid   <= i_probe.valid;
            r_fwd_valid <= we;
            r_all       <= n_all;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_addr   <= raddr;
        r_c_bit    <= i_probe.pos[BIT_W-1:0];
        r_fwd_addr <= waddr;
        r_fwd_data <= wdata;
    end

    assign o_stat.clearing = r_clearing;
    assign o_stat.inflight = r_c_valid;
    assign o_stat.all_set  = r_all;

    // no probe may reach the store while the sweep owns the write port
    a_no_probe_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_probe.valid && !r_c_valid)
        else $error("probe issued during clearing sweep");

    // a query never writes the store
    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clearing && i_func == FUNC_QUERY) |-> !we)
        else $error("store written by a query");

endmodule

// ----- rtl/bloom_filter_insert_query.sv -----
// Top level of the Bloom filter insert/query block (double hashing).
// Depends on bfiq_pkg, bfiq_probe and bfiq_rmw (which holds bfiq_ram).
`timescale 1ns / 1ps

// Usage
//   Command channel: drive i_func / i_key_hash with start high; the transfer
//   happens at a rising edge where start is high and busy is low.
//   i_func = insert sets every probed bit and gives no result;
//   i_func = query gives one result: o_maybe_present with o_valid high for
//   exactly one cycle. The receiver cannot stall; results are never held.
//   Config port: i_cfg_we / i_cfg_index / i_cfg_data, index 0 = num_bits,
//   index 1 = num_probes, other indexes ignored. Write only while idle.
// Timing
//   With h effective probes, one probe enters the store pipeline per cycle
//   (one read port, one write port, registered read). Busy drops in the
//   same cycle as a query result appears, and no new item is taken while
//   busy is high; the default is h = 7, and h = 0 also gives a result.
//   Successive probes of one insert that touch the same word are covered by
//   forwarding the last written word into the modify step.
// Reset
//   i_rst_n is synchronous, active low. After release the store is swept to
//   zero, one word per cycle, over all 1024 words with busy high; config
//   writes are still taken during the sweep.

module bloom_filter_insert_query (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [bfiq_pkg::HASH_W-1:0]       i_key_hash,
    output logic                              o_valid,
    output logic                              o_maybe_present,
    input  logic                              i_cfg_we,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bfiq_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [NUM_BITS_W-1:0]   r_num_bits;
    logic [NUM_PROBES_W-1:0] r_num_probes;
    logic                    r_func;
    logic                    r_valid;
    logic                    r_result;

    logic                    accept;
    logic                    done;
    logic                    probe_pending;
    t_probe                  probe;
    t_rmw_stat               stat;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bits   <= RST_NUM_BITS;
            r_num_probes <= RST_NUM_PROBES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NUM_BITS: begin
                    r_num_bits <= i_cfg_data;
                end
                REG_NUM_PROBES: begin
                    r_num_probes <= i_cfg_data[NUM_PROBES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---- sequencer ----
    // done: all probes issued and the last one has left the modify stage
    assign done = !probe_pending && !probe.valid && !stat.inflight;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (!stat.clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy   = 1'b1;
        accept = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy   = 1'b0;
                accept = start;
            end
            S_CLEAR, S_RUN: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_RUN) && done && (r_func == FUNC_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
        end
        r_result <= stat.all_set;
    end

    // ---- datapath ----
    bfiq_probe u_probe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_key_hash (i_key_hash),
        .i_probes   (eff_probes(r_num_probes)),
        .i_bits     (eff_bits(r_num_bits)),
        .o_probe    (probe),
        .o_pending  (probe_pending)
    );

    bfiq_rmw u_rmw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_func  (r_func),
        .i_probe (probe),
        .o_stat  (stat)
    );

    assign o_valid         = r_valid;
    assign o_maybe_present = r_result;

    // ---- checks ----
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_RUN) && (r_func == FUNC_QUERY))
        else $error("result strobe without a finished query");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("more than one result for one item");

    a_idle_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !probe_pending && !probe.valid && !stat.inflight)
        else $error("probe work left over while idle");

    a_clear_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> busy)
        else $error("command window open during clearing sweep");

endmodule
